// ===== hdl/sorted_alarm_table_scheduler_core_defines.svh =====
// Assertion helpers shared by the checking code.
`ifndef SORTED_ALARM_TABLE_SCHEDULER_CORE_DEFINES_SVH
`define SORTED_ALARM_TABLE_SCHEDULER_CORE_DEFINES_SVH

// Clocked check, masked while reset is high.
`define SATS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Clocked check that also holds across reset.
`define SATS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ===== hdl/sats_pkg.sv =====
package sats_pkg;

   localparam int TIME_W = 17;
   localparam int ACT_W  = 3;
   localparam int OP_W   = 3;
   localparam int STS_W  = 2;
   localparam int SNZ_W  = 11;

   localparam int ACT_LIGHT = 0;
   localparam int ACT_RING  = 1;
   localparam int ACT_ONCE  = 2;

   localparam int SEC_PER_MIN   = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int MIN_PER_DAY   = SEC_PER_MIN * HOURS_PER_DAY;

   localparam int MIN_W  = 13;
   localparam int QUOT_W = 12;
   localparam int DAY_W  = 11;

   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP_60 =
      RECIP_W'(((1 << RECIP_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN);

   localparam logic [SNZ_W-1:0] SNOOZE_RESET = SNZ_W'(9);

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 3'd0,
      OP_TICK   = 3'd1,
      OP_SNOOZE = 3'd2,
      OP_OFF    = 3'd3,
      OP_LIST   = 3'd4
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK      = 2'd0,
      STS_FULL    = 2'd1,
      STS_MISS    = 2'd2,
      STS_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SNZ_DIV,
      ST_SNZ_MOD,
      ST_EXEC,
      ST_LIST
   } state_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_UPDATE,
      CMD_INSERT,
      CMD_REMOVE_KEY,
      CMD_REMOVE_AT
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type      kind;
      logic [TIME_W-1:0]  key_time;
      logic [ACT_W-1:0]   key_act;
   } cell_cmd_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic              light_on;
      logic              light_off;
      logic              buzzer_on;
      logic              buzzer_off;
      logic [ACT_W-1:0]  active_actions;
      logic              entry_valid;
      logic [TIME_W-1:0] entry_time;
      logic [ACT_W-1:0]  entry_actions;
      logic              last;
   } rsp_type;

endpackage

// ===== hdl/sats_req_if.sv =====
interface sats_req_if;
   import sats_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [TIME_W-1:0]   now_seconds;
   logic [TIME_W-1:0]   alarm_time;
   logic [ACT_W-1:0]    alarm_actions;

   modport source (output valid, op, now_seconds, alarm_time, alarm_actions, input ready);
   modport sink (input valid, op, now_seconds, alarm_time, alarm_actions, output ready);
endinterface

// ===== hdl/sats_rsp_if.sv =====
interface sats_rsp_if;
   import sats_pkg::*;

   logic                valid;
   logic                ready;
   logic [STS_W-1:0]    status;
   logic                light_on;
   logic                light_off;
   logic                buzzer_on;
   logic                buzzer_off;
   logic [ACT_W-1:0]    active_actions;
   logic                entry_valid;
   logic [TIME_W-1:0]   entry_time;
   logic [ACT_W-1:0]    entry_actions;
   logic                last;

   modport source (output valid, status, light_on, light_off, buzzer_on, buzzer_off,
                   active_actions, entry_valid, entry_time, entry_actions, last,
                   input ready);
   modport sink (input valid, status, light_on, light_off, buzzer_on, buzzer_off,
                 active_actions, entry_valid, entry_time, entry_actions, last,
                 output ready);
endinterface

// ===== hdl/sats_csr_if.sv =====
interface sats_csr_if;
   import sats_pkg::*;

   logic               valid;
   logic               ready;
   logic [SNZ_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/sats_cell.sv =====
module sats_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                           clock,
   input  sats_pkg::cell_cmd_type         cmd,
   input  logic [CNT_W-1:0]               count,
   input  logic [CNT_W-1:0]               pos,
   input  logic [sats_pkg::TIME_W-1:0]    left_time,
   input  logic [sats_pkg::ACT_W-1:0]     left_act,
   input  logic                           left_lt,
   input  logic [sats_pkg::TIME_W-1:0]    right_time,
   input  logic [sats_pkg::ACT_W-1:0]     right_act,
   output logic [sats_pkg::TIME_W-1:0]    time_out,
   output logic [sats_pkg::ACT_W-1:0]     act_out,
   output logic                           lt_out,
   output logic                           eq_out
);
   import sats_pkg::*;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic              live;

   assign live     = CNT_W'(INDEX) < count;
   assign lt_out   = live && (time_ff < cmd.key_time);
   assign eq_out   = live && (time_ff == cmd.key_time);
   assign time_out = time_ff;
   assign act_out  = act_ff;

   always_comb begin
      time_in = time_ff;
      act_in  = act_ff;
      unique case (cmd.kind)
         CMD_UPDATE: begin
            if (eq_out) begin
               act_in = cmd.key_act;
            end
         end
         CMD_INSERT: begin
            if (!lt_out) begin
               if (left_lt) begin
                  time_in = cmd.key_time;
                  act_in  = cmd.key_act;
               end else begin
                  time_in = left_time;
                  act_in  = left_act;
               end
            end
         end
         CMD_REMOVE_KEY: begin
            if (!lt_out) begin
               time_in = right_time;
               act_in  = right_act;
            end
         end
         CMD_REMOVE_AT: begin
            if (CNT_W'(INDEX) >= pos) begin
               time_in = right_time;
               act_in  = right_act;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      act_ff  <= act_in;
   end

endmodule

// ===== hdl/sorted_alarm_table_scheduler_core.sv =====
// Sorted daily alarm table.
// req_if carries one operation per request: set, tick, snooze, off or list,
// with the current time and the alarm time and actions for a set.
// rsp_if returns one result per request, or one per table entry for a list (one for an empty table);
// last marks the final result of each request. csr_if writes the snooze
// length in minutes; it is ready whenever reset is low and is meant to be
// written while idle.
// A set, tick, off or unknown request goes from acceptance to ST_EXEC,
// which loads the result register; a snooze that re-arms first passes
// ST_SNZ_DIV and ST_SNZ_MOD; a list gives one result per cycle while the
// receiver takes them, max(count, 1) results in all. req_if.ready is high
// again in the cycle after the last result is loaded. Every table edit is
// made by the row of cells at once, shifting entries left or right together.
// Reset empties the table, clears the active actions and the next-alarm
// pointer and sets the snooze length to 9 minutes.
// A stalled receiver holds the result register; the block finishes its
// request only once the register can take the result, and a list waits at
// each entry.
module sorted_alarm_table_scheduler_core #(
   parameter int TABLE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   sats_req_if.sink   req_if,
   sats_rsp_if.source rsp_if,
   sats_csr_if.sink   csr_if
);
   import sats_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  key_time_ff, key_time_in;
   logic [ACT_W-1:0]   key_act_ff, key_act_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   next_ff, next_in;
   logic [ACT_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   list_cnt_ff, list_cnt_in;
   logic [SNZ_W-1:0]   snooze_ff, snooze_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   cell_cmd_type       cmd;
   logic [CNT_W-1:0]   cmd_pos;

   logic [TIME_W-1:0]  cell_time  [TABLE_DEPTH];
   logic [ACT_W-1:0]   cell_act   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_lt;
   logic [TABLE_DEPTH-1:0] cell_eq;
   logic [TIME_W-1:0]  left_time  [TABLE_DEPTH];
   logic [ACT_W-1:0]   left_act   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] left_lt;
   logic [TIME_W-1:0]  right_time [TABLE_DEPTH];
   logic [ACT_W-1:0]   right_act  [TABLE_DEPTH];

   logic                          req_fire;
   logic                          slot_free;
   logic                          found;
   logic [IDX_W-1:0]              rd_addr;
   logic [TIME_W-1:0]             rd_time;
   logic [ACT_W-1:0]              rd_act;
   logic                          list_last;
   logic [TIME_W+RECIP_W-1:0]     prod;
   logic [MIN_W-1:0]              mins_total;
   logic [MIN_W-1:0]              mins_wrap;
   logic [TIME_W-1:0]             snooze_time;

   cell_kind_type                 set_kind;
   logic [STS_W-1:0]              set_status;
   logic [CNT_W-1:0]              set_count;
   logic [CNT_W-1:0]              set_next;

   rsp_type                       res;

   // row of cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_time[g] = key_time_ff;
         assign left_act[g]  = key_act_ff;
         assign left_lt[g]   = 1'b1;
      end else begin : g_body
         assign left_time[g] = cell_time[g-1];
         assign left_act[g]  = cell_act[g-1];
         assign left_lt[g]   = cell_lt[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign right_time[g] = cell_time[g];
         assign right_act[g]  = cell_act[g];
      end else begin : g_mid
         assign right_time[g] = cell_time[g+1];
         assign right_act[g]  = cell_act[g+1];
      end

      sats_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .pos        (cmd_pos),
         .left_time  (left_time[g]),
         .left_act   (left_act[g]),
         .left_lt    (left_lt[g]),
         .right_time (right_time[g]),
         .right_act  (right_act[g]),
         .time_out   (cell_time[g]),
         .act_out    (cell_act[g]),
         .lt_out     (cell_lt[g]),
         .eq_out     (cell_eq[g])
      );
   end

   assign req_fire  = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign found     = |cell_eq;

   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_if.ready = !reset;

   assign rd_addr   = (state_ff == ST_LIST) ? list_cnt_ff : next_ff[IDX_W-1:0];
   assign rd_time   = cell_time[rd_addr];
   assign rd_act    = cell_act[rd_addr];
   assign list_last = (CNT_W'(list_cnt_ff) + CNT_W'(1)) == count_ff;

   // snooze time: minute of day by reciprocal, then wrap into one day
   assign prod       = now_ff * RECIP_60;
   assign mins_total = MIN_W'(quot_ff) + MIN_W'(snooze_ff) + MIN_W'(1);

   always_comb begin
      if (mins_total >= MIN_W'(2 * MIN_PER_DAY)) begin
         mins_wrap = mins_total - MIN_W'(2 * MIN_PER_DAY);
      end else if (mins_total >= MIN_W'(MIN_PER_DAY)) begin
         mins_wrap = mins_total - MIN_W'(MIN_PER_DAY);
      end else begin
         mins_wrap = mins_total;
      end
   end

   assign snooze_time = TIME_W'(mins_wrap[DAY_W-1:0]) * TIME_W'(SEC_PER_MIN) + TIME_W'(1);

   // set, update or delete against the key
   always_comb begin
      set_kind   = CMD_HOLD;
      set_status = STS_OK;
      set_count  = count_ff;
      set_next   = next_ff;
      if (found) begin
         if (key_act_ff == '0) begin
            set_kind  = CMD_REMOVE_KEY;
            set_count = count_ff - CNT_W'(1);
         end else begin
            set_kind = CMD_UPDATE;
         end
      end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
         set_status = STS_FULL;
      end else if (key_act_ff == '0) begin
         set_status = STS_MISS;
      end else begin
         set_kind  = CMD_INSERT;
         set_count = count_ff + CNT_W'(1);
         if (now_ff > key_time_ff && next_ff < CNT_W'(TABLE_DEPTH)) begin
            set_next = next_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.op == OP_SNOOZE && cur_ff != '0) begin
                  state_in = ST_SNZ_DIV;
               end else if (req_if.op == OP_LIST) begin
                  state_in = ST_LIST;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SNZ_DIV: state_in = ST_SNZ_MOD;
         ST_SNZ_MOD: state_in = ST_EXEC;
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (slot_free && (count_ff == '0 || list_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      now_in       = now_ff;
      key_time_in  = key_time_ff;
      key_act_in   = key_act_ff;
      quot_in      = quot_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      cur_in       = cur_ff;
      list_cnt_in  = list_cnt_ff;
      snooze_in    = snooze_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      cmd.kind     = CMD_HOLD;
      cmd.key_time = key_time_ff;
      cmd.key_act  = key_act_ff;
      cmd_pos      = next_ff;
      res          = '0;
      res.last     = 1'b1;

      if (csr_if.valid) begin
         snooze_in = csr_if.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_if.op;
               now_in      = req_if.now_seconds;
               key_time_in = req_if.alarm_time;
               key_act_in  = req_if.alarm_actions;
               list_cnt_in = '0;
            end
         end
         ST_SNZ_DIV: begin
            quot_in = prod[RECIP_SHIFT +: QUOT_W];
         end
         ST_SNZ_MOD: begin
            key_time_in = snooze_time;
            key_act_in  = cur_ff | ACT_W'(1 << ACT_ONCE);
         end
         ST_EXEC: begin
            if (slot_free) begin
               unique case (op_ff)
                  OP_SET: begin
                     cmd.kind   = set_kind;
                     res.status = set_status;
                     count_in   = set_count;
                     next_in    = set_next;
                  end
                  OP_TICK: begin
                     if (count_ff != '0) begin
                        if (next_ff < count_ff) begin
                           if (now_ff > rd_time) begin
                              cur_in        = cur_ff | rd_act;
                              res.light_on  = rd_act[ACT_LIGHT];
                              res.buzzer_on = rd_act[ACT_RING];
                              if (rd_act[ACT_ONCE]) begin
                                 cmd.kind = CMD_REMOVE_AT;
                                 count_in = count_ff - CNT_W'(1);
                              end else begin
                                 next_in = next_ff + CNT_W'(1);
                              end
                           end
                        end else if (now_ff < TIME_W'(SEC_PER_MIN)) begin
                           next_in = '0;
                        end
                     end
                  end
                  OP_SNOOZE, OP_OFF: begin
                     if (op_ff == OP_SNOOZE && cur_ff != '0) begin
                        cmd.kind   = set_kind;
                        res.status = set_status;
                        count_in   = set_count;
                        next_in    = set_next;
                     end
                     cur_in         = '0;
                     res.light_off  = 1'b1;
                     res.buzzer_off = 1'b1;
                  end
                  default: begin
                     res.status = STS_UNKNOWN;
                  end
               endcase
               res.active_actions = cur_in;
               rsp_in             = res;
               rsp_valid_in       = 1'b1;
            end
         end
         ST_LIST: begin
            if (slot_free) begin
               res.active_actions = cur_ff;
               if (count_ff != '0) begin
                  res.entry_valid   = 1'b1;
                  res.entry_time    = rd_time;
                  res.entry_actions = rd_act;
                  res.last          = list_last;
                  list_cnt_in       = list_cnt_ff + IDX_W'(1);
               end
               rsp_in       = res;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         cur_ff       <= '0;
         list_cnt_ff  <= '0;
         snooze_ff    <= SNOOZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         cur_ff       <= cur_in;
         list_cnt_ff  <= list_cnt_in;
         snooze_ff    <= snooze_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      key_time_ff <= key_time_in;
      key_act_ff  <= key_act_in;
      quot_ff     <= quot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_ff.status;
   assign rsp_if.light_on       = rsp_ff.light_on;
   assign rsp_if.light_off      = rsp_ff.light_off;
   assign rsp_if.buzzer_on      = rsp_ff.buzzer_on;
   assign rsp_if.buzzer_off     = rsp_ff.buzzer_off;
   assign rsp_if.active_actions = rsp_ff.active_actions;
   assign rsp_if.entry_valid    = rsp_ff.entry_valid;
   assign rsp_if.entry_time     = rsp_ff.entry_time;
   assign rsp_if.entry_actions  = rsp_ff.entry_actions;
   assign rsp_if.last           = rsp_ff.last;

endmodule

// ===== hdl/sats_checker.sv =====
`include "sorted_alarm_table_scheduler_core_defines.svh"

module sats_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_light_off,
   input logic [sats_pkg::ACT_W-1:0]     rsp_active_actions
);
   import sats_pkg::*;

   `SATS_ASSERT_NR(a_reset_empties_output, clock, reset |=> !rsp_valid)
   `SATS_ASSERT(a_stalled_result_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `SATS_ASSERT(a_one_request_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)
   `SATS_ASSERT(a_off_clears_actions, clock, reset,
      rsp_valid && rsp_light_off |-> rsp_active_actions == '0)

endmodule

bind sorted_alarm_table_scheduler_core sats_checker u_sats_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_light_off      (rsp_if.light_off),
   .rsp_active_actions (rsp_if.active_actions)
);

// ===== dv/tb_sorted_alarm_table_scheduler_core.sv =====
module tb_sorted_alarm_table_scheduler_core;
   import sats_pkg::*;

   localparam int TBL_DEPTH = 16;
   localparam int DAY_SECONDS = MIN_PER_DAY * SEC_PER_MIN;
   localparam int SEC_PER_HOUR = SEC_PER_MIN * SEC_PER_MIN;
   localparam int PHASE_ITEMS = 86;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [OP_W-1:0] OP_RSVD_LO = OP_W'(OP_LIST + 1);
   localparam logic [OP_W-1:0] OP_RSVD_HI = '1;
   localparam logic [ACT_W-1:0] MASK_LIGHT = ACT_W'(1 << ACT_LIGHT);
   localparam logic [ACT_W-1:0] MASK_RING = ACT_W'(1 << ACT_RING);
   localparam logic [ACT_W-1:0] MASK_ONCE = ACT_W'(1 << ACT_ONCE);

   class alarm_scoreboard;
      logic [TIME_W-1:0] slot_time[TBL_DEPTH];
      logic [ACT_W-1:0] slot_act[TBL_DEPTH];
      int unsigned n_alarms;
      int unsigned next_due;
      logic [ACT_W-1:0] ringing;
      logic [SNZ_W-1:0] snooze_len;
      rsp_type due_responses[$];
      int unsigned errors;

      function new();
         n_alarms = 0;
         next_due = 0;
         ringing = '0;
         snooze_len = SNOOZE_RESET;
         errors = 0;
         for (int k = 0; k < TBL_DEPTH; k++) begin
            slot_time[k] = '0;
            slot_act[k] = '0;
         end
      endfunction

      function int unsigned pending();
         return due_responses.size();
      endfunction

      function void drop_slot(int unsigned pos);
         for (int unsigned k = pos; k + 1 < n_alarms && k + 1 < TBL_DEPTH; k++) begin
            slot_time[k] = slot_time[k+1];
            slot_act[k] = slot_act[k+1];
         end
         if (n_alarms > 0) n_alarms--;
      endfunction

      function status_type place_alarm(logic [TIME_W-1:0] t, logic [ACT_W-1:0] a,
                                       logic [TIME_W-1:0] now);
         int unsigned pos;
         pos = 0;
         while (pos < n_alarms && slot_time[pos] < t) pos++;
         if (pos < n_alarms && slot_time[pos] == t) begin
            if (a == '0) drop_slot(pos);
            else slot_act[pos] = a;
            return STS_OK;
         end
         if (n_alarms >= TBL_DEPTH) return STS_FULL;
         if (a == '0) return STS_MISS;
         for (int unsigned k = n_alarms; k > pos; k--) begin
            slot_time[k] = slot_time[k-1];
            slot_act[k] = slot_act[k-1];
         end
         slot_time[pos] = t;
         slot_act[pos] = a;
         n_alarms++;
         if (now > t && next_due < TBL_DEPTH) next_due++;
         return STS_OK;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                 logic [TIME_W-1:0] at, logic [ACT_W-1:0] act);
         rsp_type r;
         int unsigned idx, hours, mins;
         logic [ACT_W-1:0] a;
         r = '0;
         r.status = STS_OK;
         r.last = 1'b1;
         case (op)
            OP_LIST: begin
               r.active_actions = ringing;
               if (n_alarms == 0) begin
                  due_responses.push_back(r);
                  return;
               end
               for (int unsigned k = 0; k < n_alarms; k++) begin
                  r.entry_valid = 1'b1;
                  r.entry_time = slot_time[k];
                  r.entry_actions = slot_act[k];
                  r.last = (k + 1 == n_alarms);
                  due_responses.push_back(r);
               end
               return;
            end
            OP_SET: r.status = place_alarm(at, act, now);
            OP_TICK: begin
               if (n_alarms > 0) begin
                  if (next_due < n_alarms) begin
                     idx = next_due;
                     a = slot_act[idx];
                     if (now > slot_time[idx]) begin
                        ringing |= a;
                        next_due++;
                        r.light_on = a[ACT_LIGHT];
                        r.buzzer_on = a[ACT_RING];
                        if (a[ACT_ONCE]) begin
                           drop_slot(idx);
                           next_due = idx;
                        end
                     end
                  end else if (now < SEC_PER_MIN) begin
                     next_due = 0;
                  end
               end
            end
            OP_SNOOZE, OP_OFF: begin
               if (op == OP_SNOOZE && ringing != '0) begin
                  hours = now / SEC_PER_HOUR;
                  mins = (now / SEC_PER_MIN) % SEC_PER_MIN + snooze_len + 1;
                  hours = (hours + mins / SEC_PER_MIN) % HOURS_PER_DAY;
                  mins = mins % SEC_PER_MIN;
                  r.status = place_alarm(TIME_W'(hours * SEC_PER_HOUR + mins * SEC_PER_MIN + 1),
                                         ringing | MASK_ONCE, now);
               end
               ringing = '0;
               r.light_off = 1'b1;
               r.buzzer_off = 1'b1;
            end
            default: r.status = STS_UNKNOWN;
         endcase
         r.active_actions = ringing;
         due_responses.push_back(r);
      endfunction

      function void flag(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(rsp_type seen);
         rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, seen);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         flag("status", want.status, seen.status);
         flag("light_on", want.light_on, seen.light_on);
         flag("light_off", want.light_off, seen.light_off);
         flag("buzzer_on", want.buzzer_on, seen.buzzer_on);
         flag("buzzer_off", want.buzzer_off, seen.buzzer_off);
         flag("active_actions", want.active_actions, seen.active_actions);
         flag("entry_valid", want.entry_valid, seen.entry_valid);
         flag("entry_time", want.entry_time, seen.entry_time);
         flag("entry_actions", want.entry_actions, seen.entry_actions);
         flag("last", want.last, seen.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned wall_s = 0;
   bit wrapped = 1'b0;
   alarm_scoreboard board = new();

   sats_req_if req_bus();
   sats_rsp_if rsp_bus();
   sats_csr_if csr_bus();

   sorted_alarm_table_scheduler_core #(.TABLE_DEPTH(TBL_DEPTH)) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.status = rsp_bus.status;
         seen.light_on = rsp_bus.light_on;
         seen.light_off = rsp_bus.light_off;
         seen.buzzer_on = rsp_bus.buzzer_on;
         seen.buzzer_off = rsp_bus.buzzer_off;
         seen.active_actions = rsp_bus.active_actions;
         seen.entry_valid = rsp_bus.entry_valid;
         seen.entry_time = rsp_bus.entry_time;
         seen.entry_actions = rsp_bus.entry_actions;
         seen.last = rsp_bus.last;
         board.check_result(seen);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                               input logic [TIME_W-1:0] at, input logic [ACT_W-1:0] act);
      int gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 5);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.now_seconds <= now;
      req_bus.alarm_time <= at;
      req_bus.alarm_actions <= act;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(op, now, at, act);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_snooze(input logic [SNZ_W-1:0] minutes);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= minutes;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.snooze_len = minutes;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_request();
      int pick, sel;
      logic [OP_W-1:0] op;
      logic [TIME_W-1:0] now, at;
      logic [ACT_W-1:0] act;
      pick = $urandom_range(0, 99);
      if (wrapped) begin
         pick = 50;
         wrapped = 1'b0;
      end
      now = TIME_W'(wall_s);
      at = TIME_W'($urandom_range(0, DAY_SECONDS - 1));
      act = ACT_W'($urandom_range(1, 7));
      if (pick < 35) begin
         op = OP_SET;
         sel = $urandom_range(0, 99);
         if (board.n_alarms != 0 && sel < 40)
            at = board.slot_time[$urandom_range(0, board.n_alarms - 1)];
         else if (sel < 75)
            at = TIME_W'((wall_s + $urandom_range(1, 7200)) % DAY_SECONDS);
         if ($urandom_range(0, 3) == 0) act = '0;
      end else if (pick < 65) begin
         op = OP_TICK;
      end else if (pick < 73) begin
         op = OP_SNOOZE;
      end else if (pick < 80) begin
         op = OP_OFF;
      end else if (pick < 88) begin
         op = OP_LIST;
      end else if (pick < 92) begin
         op = OP_W'(OP_RSVD_LO + $urandom_range(0, OP_RSVD_HI - OP_RSVD_LO));
      end else begin
         op = OP_W'($urandom_range(0, 7));
         now = TIME_W'($urandom);
         at = TIME_W'($urandom);
         act = ACT_W'($urandom);
      end
      send_request(op, now, at, act);
      wall_s += $urandom_range(0, 1500);
      if (wall_s >= DAY_SECONDS) begin
         wall_s = $urandom_range(0, SEC_PER_MIN - 1);
         wrapped = 1'b1;
      end
   endtask

   initial begin
      int snooze_plan[4];
      int idle_plan[4];
      int stall_plan[4];
      snooze_plan[0] = 0;
      snooze_plan[1] = (1 << SNZ_W) - 1 < MIN_PER_DAY - 1 ? 0 : MIN_PER_DAY - 1;
      snooze_plan[2] = $urandom_range(1, MIN_PER_DAY - 2);
      snooze_plan[3] = SNOOZE_RESET;
      idle_plan[0] = 0;
      idle_plan[1] = 54;
      idle_plan[2] = 0;
      idle_plan[3] = 10;
      stall_plan[0] = 0;
      stall_plan[1] = 0;
      stall_plan[2] = 54;
      stall_plan[3] = 10;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_SET;
      req_bus.now_seconds = '0;
      req_bus.alarm_time = '0;
      req_bus.alarm_actions = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(OP_LIST, '0, '0, '0);
      send_request(OP_TICK, TIME_W'(100), '0, '0);
      send_request(OP_SET, '0, TIME_W'(500), '0);
      send_request(OP_SNOOZE, '0, '0, '0);
      send_request(OP_RSVD_HI, '1, '1, '1);
      send_request(OP_SET, '0, '0, '1);
      send_request(OP_TICK, TIME_W'(1), '0, '0);
      send_request(OP_SNOOZE, TIME_W'(DAY_SECONDS - 1), '0, '0);
      send_request(OP_SET, '1, TIME_W'(DAY_SECONDS - 1), MASK_LIGHT);
      for (int k = 1; k <= 14; k++)
         send_request(OP_SET, '0, TIME_W'(k * 6000 + 7), ACT_W'(k % 7 + 1));
      send_request(OP_SET, '0, TIME_W'(3001), MASK_RING);
      send_request(OP_SET, '0, TIME_W'(6007), MASK_RING | MASK_ONCE);
      send_request(OP_SET, '0, TIME_W'(12007), '0);
      send_request(OP_LIST, '0, '0, '0);
      send_request(OP_TICK, TIME_W'(SEC_PER_MIN - 1), '0, '0);

      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         write_snooze(SNZ_W'(snooze_plan[ph]));
         send_idle_pct = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 1 && i == PHASE_ITEMS / 2) wait_drained();
            random_request();
         end
      end
      wait_drained();
      repeat (16) @(negedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
